### sv/nca_pkg.sv
// Shared types and constants of the nearest-centroid search block.
`timescale 1ns / 1ps

package nca_pkg;

  // Fixed field widths
  localparam int unsigned CH_W        = 8;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned DIST_W      = 19;
  localparam int unsigned SQ_W        = 16;
  localparam int unsigned IN_CHANNELS = 8;
  localparam int unsigned INDEX_REACH = 64;

  // Largest possible distance: eight channels of 255 squared
  localparam logic [DIST_W-1:0] DIST_MAX = 19'd520200;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned CHANS_W    = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COUNT    = 1'b0,
    CFG_CHANNELS = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef logic [CH_W-1:0]   ch_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [DIST_W-1:0] dist_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic wr_en;     // load word: write the store
    logic load_pt;   // query word: capture the point
    logic issue;     // read one centroid into the pipeline
    logic out_load;  // move the best match into the output register
  } nca_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic pipe_empty;
    logic out_free;
  } nca_sts_t;

endpackage

### sv/nca_in_if.sv
// Input channel: one load or query word.
`timescale 1ns / 1ps

interface nca_in_if;
  import nca_pkg::*;

  logic valid;
  logic ready;
  logic opcode;
  idx_t centroid_index;
  ch_t  channel_0;
  ch_t  channel_1;
  ch_t  channel_2;
  ch_t  channel_3;
  ch_t  channel_4;
  ch_t  channel_5;
  ch_t  channel_6;
  ch_t  channel_7;

  modport source (
    output valid, opcode, centroid_index,
    output channel_0, channel_1, channel_2, channel_3,
    output channel_4, channel_5, channel_6, channel_7,
    input  ready
  );

  modport sink (
    input  valid, opcode, centroid_index,
    input  channel_0, channel_1, channel_2, channel_3,
    input  channel_4, channel_5, channel_6, channel_7,
    output ready
  );
endinterface

### sv/nca_out_if.sv
// Output channel: one search result word.
`timescale 1ns / 1ps

interface nca_out_if;
  import nca_pkg::*;

  logic  valid;
  logic  ready;
  idx_t  best_index;
  dist_t best_distance;

  modport source (
    output valid, best_index, best_distance,
    input  ready
  );

  modport sink (
    input  valid, best_index, best_distance,
    output ready
  );
endinterface

### sv/nearest_centroid_argmin.sv
// Top level of the nearest-centroid search: configuration registers and wiring.
//
// Usage: words arrive on in_i. A load word (opcode 0) writes its channels into
// slot centroid_index of the centroid store and gives no result; a slot at or
// beyond NUM_CENTROIDS is ignored. A query word (opcode 1) carries a point; one
// result word on out_o gives the index and squared distance of the nearest of
// the first centroid_count centroids over the first channels_used channels,
// the lowest index on a tie. Only loaded slots may be searched.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i while
// the block is idle: index 0 is centroid_count, index 1 is channels_used.
// Timing: a load leaves the block idle. A query reads one centroid per cycle from
// the single read port of the store, all channels at once, then drains the
// pipeline and waits for a free output register before its result enters it;
// input is held off during that time.
// The output register holds a finished result while out_o stalls; a load may
// be accepted meanwhile, and the next query waits only for its own hand-off.
// Reset clears the control state, sets centroid_count to 1 and channels_used
// to 8, and leaves the centroid store unwritten.
`timescale 1ns / 1ps

module nearest_centroid_argmin #(
  parameter int unsigned NUM_CENTROIDS = 64,
  parameter int unsigned MAX_CHANNELS  = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  nca_in_if.sink                         in_i,
  nca_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [nca_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [nca_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import nca_pkg::*;

  // Slots reachable through the 6-bit index
  localparam int unsigned Depth =
    (NUM_CENTROIDS < INDEX_REACH) ? NUM_CENTROIDS : INDEX_REACH;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [COUNT_W-1:0] count_q;
  logic [CHANS_W-1:0] chans_q;
  logic [CntW-1:0]    limit;
  logic [CHANS_W-1:0] chans_eff;
  ch_t                in_ch [IN_CHANNELS];
  nca_cmd_t           cmd;
  nca_sts_t           sts;
  logic [AddrW-1:0]   addr;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_W'(1);
      chans_q <= CHANS_W'(8);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COUNT:    count_q <= cfg_data_i[COUNT_W-1:0];
        CFG_CHANNELS: chans_q <= cfg_data_i[CHANS_W-1:0];
        default:      ;
      endcase
    end
  end

  // Saturate the search count to [1, Depth] and channels to MAX_CHANNELS
  always_comb begin
    if (count_q == '0) begin
      limit = CntW'(1);
    end else if (count_q > COUNT_W'(Depth)) begin
      limit = CntW'(Depth);
    end else begin
      limit = CntW'(count_q);
    end
    chans_eff = (chans_q > CHANS_W'(MAX_CHANNELS)) ? CHANS_W'(MAX_CHANNELS) : chans_q;
  end

  assign in_ch[0] = in_i.channel_0;
  assign in_ch[1] = in_i.channel_1;
  assign in_ch[2] = in_i.channel_2;
  assign in_ch[3] = in_i.channel_3;
  assign in_ch[4] = in_i.channel_4;
  assign in_ch[5] = in_i.channel_5;
  assign in_ch[6] = in_i.channel_6;
  assign in_ch[7] = in_i.channel_7;

  nca_ctrl #(
    .AddrW (AddrW),
    .CntW  (CntW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_query_i (in_i.opcode),
    .in_ready_o (in_i.ready),
    .limit_i    (limit),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .addr_o     (addr)
  );

  nca_dp #(
    .MaxChannels (MAX_CHANNELS),
    .Depth       (Depth),
    .AddrW       (AddrW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .addr_i      (addr),
    .sts_o       (sts),
    .in_index_i  (in_i.centroid_index),
    .in_ch_i     (in_ch),
    .chans_i     (chans_eff),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_index_o (out_o.best_index),
    .out_dist_o  (out_o.best_distance)
  );

endmodule

### sv/nca_ctrl.sv
// Controller: accepts words, sequences the centroid scan, hands off the result.
`timescale 1ns / 1ps

module nca_ctrl #(
  parameter int unsigned AddrW = 6,
  parameter int unsigned CntW  = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_query_i,
  output logic              in_ready_o,
  input  logic [CntW-1:0]   limit_i,
  input  nca_pkg::nca_sts_t sts_i,
  output nca_pkg::nca_cmd_t cmd_o,
  output logic [AddrW-1:0]  addr_o
);
  import nca_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_RESULT = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            accept;
  logic            last;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign last       = (CntW'(cnt_q + 1'b1) == limit_i);
  assign addr_o     = cnt_q[AddrW-1:0];

  // Next state and commands
  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    cmd_o           = '0;
    cmd_o.wr_en     = accept && (in_query_i == OP_LOAD);
    cmd_o.load_pt   = accept && (in_query_i == OP_QUERY);
    case (state_q)
      S_IDLE: begin
        if (accept && (in_query_i == OP_QUERY)) begin
          state_d = S_SCAN;
          cnt_d   = '0;
        end
      end
      S_SCAN: begin
        cmd_o.issue = 1'b1;
        if (last) begin
          state_d = S_DRAIN;
        end else begin
          cnt_d = CntW'(cnt_q + 1'b1);
        end
      end
      S_DRAIN: begin
        if (sts_i.pipe_empty) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

`ifndef ASSERT_OFF
  // Scan never reads past the configured count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue |-> (cnt_q < limit_i))
    else $error("scan address beyond centroid count");

  // An accepted query starts the scan at slot zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_query_i == OP_QUERY) |=> (state_q == S_SCAN && cnt_q == '0))
    else $error("query did not start scan at slot zero");

  // A result is handed off only after the pipeline has drained
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> $past(sts_i.pipe_empty))
    else $error("result taken before pipeline drained");
`endif

endmodule

### sv/nca_dp.sv
// Datapath: centroid store, distance pipeline, running best and output register.
`timescale 1ns / 1ps

module nca_dp #(
  parameter int unsigned MaxChannels = 8,
  parameter int unsigned Depth       = 64,
  parameter int unsigned AddrW       = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  nca_pkg::nca_cmd_t           cmd_i,
  input  logic [AddrW-1:0]            addr_i,
  output nca_pkg::nca_sts_t           sts_o,
  input  nca_pkg::idx_t               in_index_i,
  input  nca_pkg::ch_t                in_ch_i [nca_pkg::IN_CHANNELS],
  input  logic [nca_pkg::CHANS_W-1:0] chans_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output nca_pkg::idx_t               out_index_o,
  output nca_pkg::dist_t              out_dist_o
);
  import nca_pkg::*;

  typedef logic [MaxChannels-1:0][CH_W-1:0] vec_t;

  vec_t              mem [Depth];
  vec_t              wr_vec;
  logic              wr_ok;

  vec_t              pt_q;
  vec_t              rd_data_q;
  logic              rd_v_q;
  logic [AddrW-1:0]  rd_idx_q;

  logic [SQ_W-1:0]   sq_d [MaxChannels];
  logic [SQ_W-1:0]   sq_q [MaxChannels];
  logic              sq_v_q;
  logic [AddrW-1:0]  sq_idx_q;

  dist_t             sum_d;
  dist_t             sum_q;
  logic              sum_v_q;
  logic [AddrW-1:0]  sum_idx_q;

  dist_t             best_d_q;
  logic [AddrW-1:0]  best_i_q;
  logic              take;

  logic              out_valid_q;
  idx_t              out_index_q;
  dist_t             out_dist_q;

  // Load word: gather channels, drop slots past the store
  always_comb begin
    for (int j = 0; j < MaxChannels; j++) begin
      wr_vec[j] = in_ch_i[j];
    end
  end
  assign wr_ok = (COUNT_W'(in_index_i) < COUNT_W'(Depth));

  // Centroid store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && wr_ok) begin
      mem[in_index_i[AddrW-1:0]] <= wr_vec;
    end
    if (cmd_i.issue) begin
      rd_data_q <= mem[addr_i];
    end
  end

  // Query point
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pt) begin
      pt_q <= wr_vec;
    end
  end

  // Per-channel squared difference, masked by the channel count
  always_comb begin
    logic signed [CH_W:0]     diff;
    logic signed [2*CH_W+1:0] prod;
    for (int j = 0; j < MaxChannels; j++) begin
      diff = $signed({1'b0, pt_q[j]}) - $signed({1'b0, rd_data_q[j]});
      prod = diff * diff;
      sq_d[j] = (CHANS_W'(j) < chans_i) ? prod[SQ_W-1:0] : '0;
    end
  end

  // Sum of channel squares
  always_comb begin
    sum_d = '0;
    for (int j = 0; j < MaxChannels; j++) begin
      sum_d = DIST_W'(sum_d + DIST_W'(sq_q[j]));
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q      <= sq_d;
    sq_idx_q  <= rd_idx_q;
    sum_q     <= sum_d;
    sum_idx_q <= sq_idx_q;
    rd_idx_q  <= addr_i;
  end

  // Pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q  <= 1'b0;
      sq_v_q  <= 1'b0;
      sum_v_q <= 1'b0;
    end else begin
      rd_v_q  <= cmd_i.issue;
      sq_v_q  <= rd_v_q;
      sum_v_q <= sq_v_q;
    end
  end

  // Running minimum; slot zero always opens the search, ties keep the lower slot
  assign take = sum_v_q && ((sum_idx_q == '0) || (sum_q < best_d_q));

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_d_q <= sum_q;
      best_i_q <= sum_idx_q;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_index_q <= IDX_W'(best_i_q);
      out_dist_q  <= best_d_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_index_o      = out_index_q;
  assign out_dist_o       = out_dist_q;
  assign sts_o.pipe_empty = !rd_v_q && !sq_v_q && !sum_v_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

`ifndef ASSERT_OFF
  // Distance never exceeds eight full-scale channels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_v_q |-> (sum_q <= DIST_MAX))
    else $error("distance out of range");

  // The output register is never overwritten while its word is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");

  // No store write while a scan is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_en |-> (!cmd_i.issue && !rd_v_q && !sq_v_q && !sum_v_q))
    else $error("store written during a scan");
`endif

endmodule

### tb/sv/nearest_centroid_argmin_test.sv
// Self-checking testbench of the nearest-centroid search block.
`timescale 1ns / 1ps

module nearest_centroid_argmin_test;
  import nca_pkg::*;

  localparam int unsigned NUM_SLOTS     = 64;
  localparam int unsigned SETTLE_CYCLES = 80;      // longest search plus margin
  localparam int unsigned LIMIT         = 500000;
  localparam int unsigned PHASES        = 10;
  localparam int unsigned PHASE_ITEMS   = 55;
  localparam int unsigned PLAN_ROWS     = 26;

  typedef logic [IN_CHANNELS-1:0][CH_W-1:0] vec_t;

  typedef struct packed {
    idx_t  idx;
    dist_t distance;
  } match_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    cfg_idx_e            reg_sel;
    logic [CFG_DATA_W-1:0] reg_val;
    opcode_e             op;
    idx_t                slot;
    vec_t                chans;
    logic                typed;
    idx_t                want_idx;
    dist_t               want_dist;
  } plan_row_t;

  // Directed part: register rows are applied with the block idle
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{ROW_WORD, CFG_COUNT,    7'd0, OP_LOAD,  6'd0,  {8{8'h00}}, 1'b0, 6'd0, 19'd0},
    '{ROW_WORD, CFG_COUNT,    7'd0, OP_QUERY, 6'd63, {8{8'hFF}}, 1'b1, 6'd0, DIST_MAX},
    '{ROW_WORD, CFG_COUNT,    7'd0, OP_QUERY, 6'd0,  {8{8'h00}}, 1'b1, 6'd0, 19'd0},
    '{ROW_WORD, CFG_COUNT,    7'd0, OP_LOAD,  6'd1,  {8{8'hFF}}, 1'b0, 6'd0, 19'd0},
    '{ROW_WORD, CFG_COUNT,    7'd0, OP_LOAD,  6'd2,  {8{8'hFF}}, 1'b0, 6'd0, 19'd0},
    '{ROW_WORD, CFG_COUNT,    7'd0, OP_LOAD,  6'd3,  {4{16'hAA55}}, 1'b0, 6'd0, 19'd0},
    '{ROW_WORD, CFG_COUNT,    7'd0, OP_LOAD,  6'd63, 64'h0123456789ABCDEF, 1'b0, 6'd0, 19'd0},
    '{ROW_CFG,  CFG_COUNT,    7'd4, OP_LOAD,  6'd0,  64'h0, 1'b0, 6'd0, 19'd0},
    // slots 1 and 2 tie at zero: lower one wins
    '{ROW_WORD, CFG_COUNT,    7'd0, OP_QUERY, 6'd5,  {8{8'hFF}}, 1'b1, 6'd1, 19'd0},
    '{ROW_WORD, CFG_COUNT,    7'd0, OP_QUERY, 6'd0,  {4{16'h55AA}}, 1'b0, 6'd0, 19'd0},
    '{ROW_WORD, CFG_COUNT,    7'd0, OP_QUERY, 6'd0,  64'h0102030405060708, 1'b0, 6'd0, 19'd0},
    // zero count searches slot 0 only
    '{ROW_CFG,  CFG_COUNT,    7'd0, OP_LOAD,  6'd0,  64'h0, 1'b0, 6'd0, 19'd0},
    '{ROW_WORD, CFG_COUNT,    7'd0, OP_QUERY, 6'd0,  {8{8'hFF}}, 1'b1, 6'd0, DIST_MAX},
    // no channels: every distance is zero
    '{ROW_CFG,  CFG_CHANNELS, 7'd0, OP_LOAD,  6'd0,  64'h0, 1'b0, 6'd0, 19'd0},
    '{ROW_CFG,  CFG_COUNT,    7'd4, OP_LOAD,  6'd0,  64'h0, 1'b0, 6'd0, 19'd0},
    '{ROW_WORD, CFG_COUNT,    7'd0, OP_QUERY, 6'd0,  64'h123456789ABCDEF0, 1'b1, 6'd0, 19'd0},
    // channel count above eight saturates
    '{ROW_CFG,  CFG_CHANNELS, 7'd15, OP_LOAD, 6'd0,  64'h0, 1'b0, 6'd0, 19'd0},
    '{ROW_WORD, CFG_COUNT,    7'd0, OP_QUERY, 6'd0,  {8{8'h00}}, 1'b1, 6'd0, 19'd0},
    '{ROW_WORD, CFG_COUNT,    7'd0, OP_QUERY, 6'd0,  {8{8'hFF}}, 1'b1, 6'd1, 19'd0},
    '{ROW_CFG,  CFG_CHANNELS, 7'd1, OP_LOAD,  6'd0,  64'h0, 1'b0, 6'd0, 19'd0},
    '{ROW_WORD, CFG_COUNT,    7'd0, OP_QUERY, 6'd0,  64'h00000000000000FF, 1'b0, 6'd0, 19'd0},
    '{ROW_WORD, CFG_COUNT,    7'd0, OP_QUERY, 6'd0,  64'h0000000000000080, 1'b0, 6'd0, 19'd0},
    '{ROW_WORD, CFG_COUNT,    7'd0, OP_LOAD,  6'd0,  64'hFFFFFFFFFFFFFF80, 1'b0, 6'd0, 19'd0},
    '{ROW_WORD, CFG_COUNT,    7'd0, OP_QUERY, 6'd0,  64'h0000000000000080, 1'b0, 6'd0, 19'd0},
    '{ROW_CFG,  CFG_CHANNELS, 7'd8, OP_LOAD,  6'd0,  64'h0, 1'b0, 6'd0, 19'd0},
    '{ROW_CFG,  CFG_COUNT,    7'd1, OP_LOAD,  6'd0,  64'h0, 1'b0, 6'd0, 19'd0}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  nca_in_if  in_ch ();
  nca_out_if out_ch ();

  nearest_centroid_argmin uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Predictor state: centroid table and register copies
  vec_t                cent_tbl [NUM_SLOTS];
  bit                  loaded_slot [NUM_SLOTS];
  logic [COUNT_W-1:0]  reg_count = 7'd1;
  logic [CHANS_W-1:0]  reg_chans = 4'd8;

  match_t      pending_matches [$];
  int unsigned mismatches = 0;
  bit          gaps_on   = 1'b1;
  bit          stalls_on = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Number of slots a query walks
  function automatic int search_span();
    int c;
    c = reg_count;
    if (c == 0) c = 1;
    if (c > INDEX_REACH) c = INDEX_REACH;
    return c;
  endfunction

  // Nearest stored centroid to a point; first one wins a tie
  function automatic match_t nearest_to(vec_t pt);
    int     nch;
    int     d;
    int     diff;
    match_t best;
    nch  = (reg_chans > IN_CHANNELS) ? IN_CHANNELS : reg_chans;
    best = '0;
    for (int i = 0; i < search_span(); i++) begin
      d = 0;
      for (int j = 0; j < nch; j++) begin
        diff = int'(pt[j]) - int'(cent_tbl[i][j]);
        d += diff * diff;
      end
      if (i == 0 || d < best.distance) begin
        best.idx      = idx_t'(i);
        best.distance = dist_t'(d);
      end
    end
    return best;
  endfunction

  function automatic void report_bad(string what, match_t want, match_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t ns: %s: expected idx %0d dist %0d, got idx %0d dist %0d",
               $realtime, what, want.idx, want.distance, got.idx, got.distance);
  endfunction

  // Present one word and hold it until accepted; valid stays high afterwards
  task automatic offer_word(opcode_e op, idx_t slot, vec_t chans, bit use_typed,
                            match_t typed);
    if (gaps_on && $urandom_range(3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.opcode         <= op;
    in_ch.centroid_index <= slot;
    in_ch.channel_0      <= chans[0];
    in_ch.channel_1      <= chans[1];
    in_ch.channel_2      <= chans[2];
    in_ch.channel_3      <= chans[3];
    in_ch.channel_4      <= chans[4];
    in_ch.channel_5      <= chans[5];
    in_ch.channel_6      <= chans[6];
    in_ch.channel_7      <= chans[7];
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    if (op == OP_LOAD) begin
      cent_tbl[slot]    = chans;
      loaded_slot[slot] = 1'b1;
    end else begin
      pending_matches.push_back(use_typed ? typed : nearest_to(chans));
    end
  endtask

  // Register write once the block has gone quiet
  task automatic write_reg(cfg_idx_e sel, logic [CFG_DATA_W-1:0] val);
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_matches.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sel;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (sel == CFG_COUNT) reg_count = val;
    else reg_chans = val[CHANS_W-1:0];
  endtask

  // Result side: random stall bursts
  initial begin : result_ready
    int hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) hold--;
      else if (stalls_on && $urandom_range(4) == 0) hold = $urandom_range(4, 1);
      out_ch.ready <= (hold == 0);
    end
  end

  // Compare each result word against the oldest expectation
  always @(posedge clk_i) begin : result_check
    match_t got;
    match_t want;
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.idx      = out_ch.best_index;
      got.distance = out_ch.best_distance;
      if (pending_matches.size() == 0) begin
        report_bad("unexpected result", '0, got);
      end else begin
        want = pending_matches.pop_front();
        if (got.idx !== want.idx || got.distance !== want.distance)
          report_bad("result mismatch", want, got);
      end
    end
  end

  initial begin : watchdog
    for (int c = 0; c < LIMIT; c++) @(posedge clk_i);
    $display("timeout after %0d cycles", LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    vec_t        pt;
    idx_t        slot;
    match_t      typed_match;
    int          span;
    int          first_free;
    int          donor;
    bit          want_query;
    logic [CFG_DATA_W-1:0] cnt_val;
    logic [CFG_DATA_W-1:0] chs_val;

    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_idx_i            <= CFG_COUNT;
    cfg_data_i           <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.opcode         <= OP_LOAD;
    in_ch.centroid_index <= '0;
    in_ch.channel_0      <= '0;
    in_ch.channel_1      <= '0;
    in_ch.channel_2      <= '0;
    in_ch.channel_3      <= '0;
    in_ch.channel_4      <= '0;
    in_ch.channel_5      <= '0;
    in_ch.channel_6      <= '0;
    in_ch.channel_7      <= '0;
    foreach (loaded_slot[i]) loaded_slot[i] = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (PLAN[r].kind == ROW_CFG) begin
        write_reg(PLAN[r].reg_sel, PLAN[r].reg_val);
      end else begin
        typed_match.idx      = PLAN[r].want_idx;
        typed_match.distance = PLAN[r].want_dist;
        offer_word(PLAN[r].op, PLAN[r].slot, PLAN[r].chans, PLAN[r].typed, typed_match);
      end
    end

    // Random phases, each with its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin cnt_val = 7'd8;   chs_val = 7'd8;  end
        1: begin cnt_val = 7'd64;  chs_val = 7'd15; end
        2: begin cnt_val = 7'd127; chs_val = 7'd8;  end
        default: begin
          case ($urandom_range(9))
            0:       cnt_val = 7'd0;
            1:       cnt_val = 7'd1;
            2:       cnt_val = 7'd64;
            3:       cnt_val = 7'($urandom_range(127, 65));
            default: cnt_val = 7'($urandom_range(16, 1));
          endcase
          case ($urandom_range(6))
            0:       chs_val = 7'd0;
            1:       chs_val = 7'd1;
            2:       chs_val = 7'd15;
            3:       chs_val = 7'($urandom_range(15, 9));
            default: chs_val = 7'($urandom_range(8, 1));
          endcase
        end
      endcase
      write_reg(CFG_COUNT, cnt_val);
      write_reg(CFG_CHANNELS, chs_val);
      gaps_on   = (ph != PHASES - 1) && ($urandom_range(3) != 0);
      stalls_on = (ph != PHASES - 1) && ($urandom_range(3) != 0);

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // hold off the sender until every result is back
        if ((ph == 3 || ph == 6) && k == PHASE_ITEMS / 2) begin
          in_ch.valid <= 1'b0;
          do @(posedge clk_i); while (pending_matches.size() != 0);
        end

        span       = search_span();
        first_free = -1;
        for (int i = span - 1; i >= 0; i--)
          if (!loaded_slot[i]) first_free = i;
        for (int j = 0; j < IN_CHANNELS; j++)
          case ($urandom_range(5))
            0:       pt[j] = 8'h00;
            1:       pt[j] = 8'hFF;
            default: pt[j] = 8'($urandom);
          endcase
        slot       = idx_t'($urandom);
        donor      = $urandom_range(NUM_SLOTS - 1);
        want_query = ($urandom_range(9) < 6);

        // queries only once every searched slot holds a centroid
        if (want_query && first_free < 0) begin
          if ($urandom_range(3) == 0) pt = cent_tbl[$urandom_range(span - 1)];
          offer_word(OP_QUERY, slot, pt, 1'b0, '0);
        end else begin
          if (first_free >= 0 && (want_query || $urandom_range(1) == 0))
            slot = idx_t'(first_free);
          // copies of a stored centroid make ties
          if (loaded_slot[donor] && $urandom_range(3) == 0) pt = cent_tbl[donor];
          offer_word(OP_LOAD, slot, pt, 1'b0, '0);
        end
      end
    end

    // Drain, then let the block settle
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_matches.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_matches.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
